// ===== design/crmw_pkg.sv =====
// Shared types, constants and arithmetic step functions for the centred RMSProp core.
// No dependencies; every other file of the block imports this package.
package crmw_pkg;

    localparam int DEFAULT_NUM_PARAMS = 1024;

    localparam int IDX_W      = 10;
    localparam int WORD_W     = 32;
    localparam int MS_W       = 48;
    localparam int GAMMA_W    = 17;
    localparam int RATE_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int PROD_W     = 63;          // learn_rate * |grad|
    localparam int AVG_W      = MS_W + WORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAMMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON     = 2'd2;

    localparam logic [GAMMA_W-1:0] GAMMA_ONE        = 17'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET      = 17'd58982;
    localparam logic [RATE_W-1:0]  LEARN_RATE_RESET = 31'd16777;
    localparam logic [RATE_W-1:0]  EPSILON_RESET    = 31'd17;
    localparam logic [RATE_W-1:0]  EPSILON_MIN      = 31'd1;

    localparam logic [WORD_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WEIGHT_MIN = 32'h8000_0000;

    // square root: radicand, root, partial remainder
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int SQ_REM_W    = 35;
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

    // divider: quotient bits, divisor 2*root
    localparam int QUOT_W      = 32;
    localparam int DVS_W       = ROOT_W + 1;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = 1 + QUOT_W / DIV_STEPS;

    localparam int AVG_STAGES  = 4;
    // register stages from the read stage up to the last divider stage
    localparam int PIPE_DEPTH  = 1 + AVG_STAGES + SQRT_STAGES + DIV_STAGES;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_UPDATE = 1'b1
    } crmw_req_t;

    typedef struct packed {
        crmw_req_t                req_type;
        logic [IDX_W-1:0]         param_index;
        logic signed [WORD_W-1:0] weight_value;
        logic signed [WORD_W-1:0] grad_sum;
    } crmw_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [WORD_W-1:0] new_weight;
        logic                     saturated;
    } crmw_out_t;

    typedef struct packed {
        logic [GAMMA_W-1:0] decay_gamma;
        logic [RATE_W-1:0]  learn_rate;
        logic [RATE_W-1:0]  epsilon;
    } crmw_cfg_t;

    // per-item sideband that travels down the pipeline
    typedef struct packed {
        crmw_req_t                req;
        logic [IDX_W-1:0]         idx;
        logic                     in_range;
        logic signed [WORD_W-1:0] wval;
        logic                     grad_neg;
        logic signed [WORD_W-1:0] w_old;
        logic [MS_W-1:0]          ms;
        logic signed [WORD_W-1:0] mg;
        logic [PROD_W-1:0]        lrg;
    } crmw_side_t;

    typedef struct packed {
        logic [RAD_W-1:0]    rad;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } crmw_sq_t;

    typedef struct packed {
        logic [QUOT_W-1:0] num;
        logic [DVS_W-1:0]  rem;
        logic [DVS_W-1:0]  dvs;
        logic [QUOT_W-1:0] quot;
        logic              ovf;
    } crmw_dv_t;

    // one digit of the bit-pair square root
    function automatic crmw_sq_t sqrt_step(input crmw_sq_t s);
        crmw_sq_t            r;
        logic [SQ_REM_W-1:0] cur;
        logic [SQ_REM_W-1:0] trial;
        cur   = {s.rem[SQ_REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = cur - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one bit of restoring division
    function automatic crmw_dv_t div_step(input crmw_dv_t s);
        crmw_dv_t         r;
        logic [DVS_W:0]   cur;
        logic [DVS_W:0]   dif;
        cur    = {s.rem, s.num[QUOT_W-1]};
        dif    = cur - {1'b0, s.dvs};
        r      = s;
        r.num  = {s.num[QUOT_W-2:0], 1'b0};
        if (cur >= {1'b0, s.dvs}) begin
            r.rem  = dif[DVS_W-1:0];
            r.quot = {s.quot[QUOT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur[DVS_W-1:0];
            r.quot = {s.quot[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== design/crmw_avg.sv =====
// Running-average update and root argument: four register stages.
// Depends on crmw_pkg.
module crmw_avg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  crmw_pkg::crmw_side_t                in_side,
    input  logic signed [crmw_pkg::WORD_W-1:0]  in_grad,
    input  crmw_pkg::crmw_cfg_t                 cfg,
    output logic                                out_valid,
    output crmw_pkg::crmw_side_t                out_side,
    output logic [crmw_pkg::RAD_W-1:0]          out_rad
);
    import crmw_pkg::*;

    logic [GAMMA_W-1:0] gam;
    logic [GAMMA_W-1:0] inv;
    logic [RATE_W-1:0]  eps1;
    logic [WORD_W-1:0]  gabs;

    // stage A: products
    logic               a_valid_reg;
    crmw_side_t         a_side_reg, a_side_next;
    logic [63:0]        a_gsq_reg, a_gsq_next;
    logic [40:0]        a_msl_reg, a_msl_next;
    logic [40:0]        a_msh_reg, a_msh_next;
    logic signed [49:0] a_mg_reg, a_mg_next;
    logic signed [49:0] a_ig_reg, a_ig_next;

    // stage B
    logic               b_valid_reg;
    crmw_side_t         b_side_reg, b_side_next;
    logic [47:0]        b_gsq;
    logic [40:0]        b_gl_reg, b_gl_next;
    logic [40:0]        b_gh_reg, b_gh_next;
    logic [65:0]        b_acc_reg, b_acc_next;
    logic signed [49:0] b_mgsum;

    // stage C
    logic               c_valid_reg;
    crmw_side_t         c_side_reg, c_side_next;
    logic [65:0]        c_sum;
    logic [WORD_W-1:0]  c_mgabs;
    logic [63:0]        c_mgsq_reg, c_mgsq_next;

    // stage D
    logic               d_valid_reg;
    crmw_side_t         d_side_reg;
    logic [MS_W-1:0]    d_mgsq;
    logic [MS_W-1:0]    d_diff;
    logic [48:0]        d_arg;
    logic [RAD_W-1:0]   d_rad_reg, d_rad_next;

    assign gam  = (cfg.decay_gamma > GAMMA_ONE) ? GAMMA_ONE : cfg.decay_gamma;
    assign inv  = GAMMA_ONE - gam;
    assign eps1 = (cfg.epsilon == '0) ? EPSILON_MIN : cfg.epsilon;
    assign gabs = in_grad[WORD_W-1] ? WORD_W'(-in_grad) : WORD_W'(in_grad);

    always_comb
    begin
        a_side_next          = in_side;
        a_side_next.grad_neg = in_grad[WORD_W-1];
        a_side_next.lrg      = {32'd0, in_side.lrg[RATE_W-1:0]} * {31'd0, gabs};
        a_gsq_next           = {32'd0, gabs} * {32'd0, gabs};
        a_msl_next           = {24'd0, gam} * {17'd0, in_side.ms[23:0]};
        a_msh_next           = {24'd0, gam} * {17'd0, in_side.ms[47:24]};
        a_mg_next            = $signed({33'd0, gam}) * $signed({{18{in_side.mg[31]}}, in_side.mg});
        a_ig_next            = $signed({33'd0, inv}) * $signed({{18{in_grad[31]}}, in_grad});
    end

    always_comb
    begin
        b_gsq          = a_gsq_reg[63:16];
        b_gl_next      = {24'd0, inv} * {17'd0, b_gsq[23:0]};
        b_gh_next      = {24'd0, inv} * {17'd0, b_gsq[47:24]};
        b_acc_next     = {1'b0, a_msh_reg, 24'd0} + {25'd0, a_msl_reg};
        b_mgsum        = a_mg_reg + a_ig_reg;
        b_side_next    = a_side_reg;
        // arithmetic shift: floor toward minus infinity
        b_side_next.mg = b_mgsum[47:16];
    end

    always_comb
    begin
        c_sum          = b_acc_reg + {1'b0, b_gh_reg, 24'd0} + {25'd0, b_gl_reg};
        c_side_next    = b_side_reg;
        c_side_next.ms = c_sum[63:16];
        c_mgabs        = b_side_reg.mg[WORD_W-1] ? WORD_W'(-b_side_reg.mg)
                                                 : WORD_W'(b_side_reg.mg);
        c_mgsq_next    = {32'd0, c_mgabs} * {32'd0, c_mgabs};
    end

    always_comb
    begin
        d_mgsq     = c_mgsq_reg[63:16];
        d_diff     = (c_side_reg.ms > d_mgsq) ? (c_side_reg.ms - d_mgsq) : '0;
        d_arg      = {1'b0, d_diff} + {10'd0, eps1, 8'd0};
        d_rad_next = {1'b0, d_arg, 14'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= a_side_next;
            a_gsq_reg  <= a_gsq_next;
            a_msl_reg  <= a_msl_next;
            a_msh_reg  <= a_msh_next;
            a_mg_reg   <= a_mg_next;
            a_ig_reg   <= a_ig_next;
            b_side_reg <= b_side_next;
            b_gl_reg   <= b_gl_next;
            b_gh_reg   <= b_gh_next;
            b_acc_reg  <= b_acc_next;
            c_side_reg <= c_side_next;
            c_mgsq_reg <= c_mgsq_next;
            d_side_reg <= c_side_reg;
            d_rad_reg  <= d_rad_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_side  = d_side_reg;
    assign out_rad   = d_rad_reg;

endmodule

// ===== design/crmw_isqrt.sv =====
// Pipelined integer square root, four digits (SQRT_STEPS) per register stage.
// Depends on crmw_pkg.
module crmw_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  crmw_pkg::crmw_side_t          in_side,
    input  logic [crmw_pkg::RAD_W-1:0]    in_rad,
    output logic                          out_valid,
    output crmw_pkg::crmw_side_t          out_side,
    output logic [crmw_pkg::ROOT_W-1:0]   out_root
);
    import crmw_pkg::*;

    logic       v_reg    [SQRT_STAGES];
    crmw_side_t side_reg [SQRT_STAGES];
    crmw_sq_t   sq_reg   [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        logic       v_in;
        crmw_side_t side_in;
        crmw_sq_t   sq_in;
        crmw_sq_t   sq_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign side_in = in_side;
            assign sq_in   = '{rad: in_rad, rem: '0, root: '0};
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
            assign sq_in   = sq_reg[k-1];
        end

        always_comb
        begin
            sq_next = sq_in;
            for (int i = 0; i < SQRT_STEPS; i++)
            begin
                sq_next = sqrt_step(sq_next);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_in;
                sq_reg[k]   <= sq_next;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];
    assign out_root  = sq_reg[SQRT_STAGES-1].root;

endmodule

// ===== design/crmw_div.sv =====
// Pipelined restoring divider: step = (lr*|g|) / (2*root), flagged when >= 2^32.
// Depends on crmw_pkg.
module crmw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  crmw_pkg::crmw_side_t          in_side,
    input  logic [crmw_pkg::ROOT_W-1:0]   in_root,
    output logic                          out_valid,
    output crmw_pkg::crmw_side_t          out_side,
    output logic [crmw_pkg::QUOT_W-1:0]   out_quot,
    output logic                          out_ovf
);
    import crmw_pkg::*;

    localparam int STEP_STAGES = DIV_STAGES - 1;

    logic       v_reg    [DIV_STAGES];
    crmw_side_t side_reg [DIV_STAGES];
    crmw_dv_t   dv_reg   [DIV_STAGES];
    crmw_dv_t   prep_next;

    // set-up stage: divisor, top of the dividend as first remainder, overflow test
    always_comb
    begin
        prep_next.dvs  = {in_root, 1'b0};
        prep_next.rem  = {2'd0, in_side.lrg[PROD_W-1:QUOT_W]};
        prep_next.num  = in_side.lrg[QUOT_W-1:0];
        prep_next.quot = '0;
        prep_next.ovf  = ({2'd0, in_side.lrg[PROD_W-1:QUOT_W]} >= prep_next.dvs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            dv_reg[0]   <= prep_next;
        end
    end

    for (genvar k = 1; k <= STEP_STAGES; k++)
    begin : g_stage
        crmw_dv_t dv_next;

        always_comb
        begin
            dv_next = dv_reg[k-1];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                dv_next = div_step(dv_next);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= side_reg[k-1];
                dv_reg[k]   <= dv_next;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_quot  = dv_reg[DIV_STAGES-1].quot;
    assign out_ovf   = dv_reg[DIV_STAGES-1].ovf;

endmodule

// ===== design/centered_rmsprop_weight_update_core.sv =====
// Centred RMSProp optimiser core: top level with parameter stores, hazard control and output.
// Depends on crmw_pkg, crmw_avg, crmw_isqrt and crmw_div.
//
// The core accepts one item per clock when nothing holds it, and returns one result item per
// request, in order. The pipeline is one read stage on the weight and average stores, four
// stages of average update, eight stages of square root (four digits each), and nine stages
// of division (set-up plus four quotient bits each), followed by the output register. Items
// to different entries stream at full rate while the output is not stalled; an item whose
// entry still has an earlier item in flight is held at the input until that item has written
// back. After reset the core clears the average store one entry a cycle, every entry in turn,
// before it takes the first item; configuration writes are taken throughout. A stall on the
// output freezes the whole pipeline in place.
module centered_rmsprop_weight_update_core #(
    parameter int NUM_PARAMS = crmw_pkg::DEFAULT_NUM_PARAMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  crmw_pkg::crmw_in_t                  req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output crmw_pkg::crmw_out_t                 rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crmw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crmw_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import crmw_pkg::*;

    localparam int ADDR_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam logic [16:0]       NUM_LIM   = 17'(NUM_PARAMS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PARAMS - 1);

    // configuration
    crmw_cfg_t cfg_reg;

    // reset clearing pass over the average store
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // handshake
    logic adv;
    logic accept;
    logic in_range;
    logic hazard;
    logic [ADDR_W-1:0] rd_addr;

    // stores
    logic [AVG_W-1:0]  avg_mem [NUM_PARAMS];
    logic [WORD_W-1:0] wgt_mem [NUM_PARAMS];

    // read stage
    logic                     s1_valid_reg;
    crmw_in_t                 s1_in_reg;
    logic                     s1_range_reg;
    logic [AVG_W-1:0]         s1_avg_reg;
    logic [WORD_W-1:0]        s1_wgt_reg;
    crmw_side_t               s1_side;

    // in-flight record, one slot per pipeline stage
    logic             trk_valid_reg [PIPE_DEPTH];
    logic [IDX_W-1:0] trk_idx_reg   [PIPE_DEPTH];

    // stage links
    logic              avg_valid;
    crmw_side_t        avg_side;
    logic [RAD_W-1:0]  avg_rad;
    logic              sq_valid;
    crmw_side_t        sq_side;
    logic [ROOT_W-1:0] sq_root;
    logic              dv_valid;
    crmw_side_t        dv_side;
    logic [QUOT_W-1:0] dv_quot;
    logic              dv_ovf;

    // write-back
    logic [DVS_W-1:0]         wb_step;
    logic signed [34:0]       wb_wide;
    logic [WORD_W-1:0]        wb_upd;
    logic                     wb_sat;
    logic                     wb_en;
    logic [WORD_W-1:0]        wb_wgt;
    logic [AVG_W-1:0]         wb_avg;
    logic                     avg_we;
    logic [ADDR_W-1:0]        avg_waddr;
    logic [AVG_W-1:0]         avg_wdata;
    logic [ADDR_W-1:0]        wb_addr;

    // output register
    logic      rsp_valid_reg;
    crmw_out_t rsp_data_reg, rsp_data_next;

    // ---------------------------------------------------------------- configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_gamma <= GAMMA_RESET;
            cfg_reg.learn_rate  <= LEARN_RATE_RESET;
            cfg_reg.epsilon     <= EPSILON_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DECAY_GAMMA: cfg_reg.decay_gamma <= cfg_data[GAMMA_W-1:0];
                CFG_LEARN_RATE:  cfg_reg.learn_rate  <= cfg_data[RATE_W-1:0];
                CFG_EPSILON:     cfg_reg.epsilon     <= cfg_data[RATE_W-1:0];
                default:         ;   // unused index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------- clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_ADDR)
                clear_busy_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- input side
    // The whole pipeline moves as one; it stands only while a result waits at the output.
    assign adv      = !rsp_valid_reg || rsp_ready;
    assign in_range = (17'(req_data.param_index) < NUM_LIM);
    assign rd_addr  = ADDR_W'(req_data.param_index);

    // hold an item whose entry still has an earlier item in flight
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            if (trk_valid_reg[k] && (trk_idx_reg[k] == req_data.param_index))
                hazard = 1'b1;
        end
    end

    assign req_ready = adv && !clear_busy_reg && !hazard;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
                trk_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            trk_valid_reg[0] <= accept && in_range;
            for (int k = 1; k < PIPE_DEPTH; k++)
                trk_valid_reg[k] <= trk_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trk_idx_reg[0] <= req_data.param_index;
            for (int k = 1; k < PIPE_DEPTH; k++)
                trk_idx_reg[k] <= trk_idx_reg[k-1];
        end
    end

    // ---------------------------------------------------------------- stores and read stage
    always_ff @(posedge clk)
    begin
        if (avg_we)
            avg_mem[avg_waddr] <= avg_wdata;
        if (accept)
            s1_avg_reg <= avg_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wb_en)
            wgt_mem[wb_addr] <= wb_wgt;
        if (accept)
            s1_wgt_reg <= wgt_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_reg    <= req_data;
            s1_range_reg <= in_range;
        end
    end

    // the product field carries the learning rate into the first arithmetic stage
    always_comb
    begin
        s1_side.req      = s1_in_reg.req_type;
        s1_side.idx      = s1_in_reg.param_index;
        s1_side.in_range = s1_range_reg;
        s1_side.wval     = s1_in_reg.weight_value;
        s1_side.grad_neg = s1_in_reg.grad_sum[WORD_W-1];
        s1_side.w_old    = s1_wgt_reg;
        s1_side.ms       = s1_avg_reg[AVG_W-1:WORD_W];
        s1_side.mg       = s1_avg_reg[WORD_W-1:0];
        s1_side.lrg      = {32'd0, cfg_reg.learn_rate};
    end

    // ---------------------------------------------------------------- arithmetic
    crmw_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .in_side   (s1_side),
        .in_grad   (s1_in_reg.grad_sum),
        .cfg       (cfg_reg),
        .out_valid (avg_valid),
        .out_side  (avg_side),
        .out_rad   (avg_rad)
    );

    crmw_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (avg_valid),
        .in_side   (avg_side),
        .in_rad    (avg_rad),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    crmw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_side   (sq_side),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quot  (dv_quot),
        .out_ovf   (dv_ovf)
    );

    // ---------------------------------------------------------------- write-back
    // A quotient of 2^32 or more always drives the weight past either bound.
    always_comb
    begin
        wb_step = dv_ovf ? '1 : {1'b0, dv_quot};
        if (dv_side.grad_neg)
            wb_wide = {{3{dv_side.w_old[WORD_W-1]}}, dv_side.w_old} + {2'b00, wb_step};
        else
            wb_wide = {{3{dv_side.w_old[WORD_W-1]}}, dv_side.w_old} - {2'b00, wb_step};

        if (!wb_wide[34] && (wb_wide[34:31] != 4'h0))
        begin
            wb_upd = WEIGHT_MAX;
            wb_sat = 1'b1;
        end
        else if (wb_wide[34] && (wb_wide[34:31] != 4'hF))
        begin
            wb_upd = WEIGHT_MIN;
            wb_sat = 1'b1;
        end
        else
        begin
            wb_upd = wb_wide[WORD_W-1:0];
            wb_sat = 1'b0;
        end

        rsp_data_next.out_index = dv_side.idx;
        if (!dv_side.in_range)
        begin
            rsp_data_next.new_weight = '0;
            rsp_data_next.saturated  = 1'b0;
            wb_wgt                   = '0;
            wb_avg                   = '0;
        end
        else if (dv_side.req == REQ_LOAD)
        begin
            rsp_data_next.new_weight = dv_side.wval;
            rsp_data_next.saturated  = 1'b0;
            wb_wgt                   = dv_side.wval;
            wb_avg                   = '0;
        end
        else
        begin
            rsp_data_next.new_weight = wb_upd;
            rsp_data_next.saturated  = wb_sat;
            wb_wgt                   = wb_upd;
            wb_avg                   = {dv_side.ms, dv_side.mg};
        end
    end

    assign wb_en     = adv && dv_valid && dv_side.in_range;
    assign wb_addr   = ADDR_W'(dv_side.idx);
    assign avg_we    = clear_busy_reg || wb_en;
    assign avg_waddr = clear_busy_reg ? clear_addr_reg : wb_addr;
    assign avg_wdata = clear_busy_reg ? '0 : wb_avg;

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the centred RMSProp weight update core.
// Depends on crmw_pkg and centered_rmsprop_weight_update_core with its submodules.
`timescale 1ns / 1ps

module tb_top;
    import crmw_pkg::*;

    localparam int NPARAM      = 1024;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 40;     // more than the 22 pipeline stages and the output register
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       req_valid = 1'b0;
    logic       req_ready;
    crmw_in_t   req_data = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    crmw_out_t  rsp_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DECAY_GAMMA;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    centered_rmsprop_weight_update_core #(.NUM_PARAMS(NPARAM)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block: stores and registers as the core should hold them
    int                     weight_mirror [NPARAM];
    logic [MS_W-1:0]        msq_mirror    [NPARAM];
    int                     mgrad_mirror  [NPARAM];
    logic [GAMMA_W-1:0]     gamma_reg = GAMMA_RESET;
    logic [RATE_W-1:0]      rate_reg  = LEARN_RATE_RESET;
    logic [RATE_W-1:0]      eps_reg   = EPSILON_RESET;

    crmw_in_t  pending_items [$];
    crmw_out_t expected_weights [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic send_paused = 1'b0;
    logic hold_go = 1'b0;
    int  hold_left = 0;
    int  err_cnt = 0;
    int  items_in = 0;
    int  items_out = 0;
    int  sat_seen = 0;
    int  load_seen = 0;
    int  cycle_cnt = 0;

    // Work out the result of one request and advance the shadow stores
    function automatic crmw_out_t apply_request(crmw_in_t r);
        crmw_out_t o;
        int unsigned i;
        longint unsigned gam, inv, eps_v, gabs, gsq, ms_n, mgabs, mgsq, arg, x, root, bit_v, step;
        longint mgsum, mg_n, w;
        o.out_index  = r.param_index;
        o.new_weight = '0;
        o.saturated  = 1'b0;
        i = r.param_index;
        if (r.req_type == REQ_LOAD) begin
            weight_mirror[i] = r.weight_value;
            msq_mirror[i]    = '0;
            mgrad_mirror[i]  = 0;
            o.new_weight     = r.weight_value;
            return o;
        end
        gam   = (gamma_reg > GAMMA_ONE) ? 64'd65536 : 64'(gamma_reg);
        inv   = 64'd65536 - gam;
        eps_v = (eps_reg == '0) ? 64'd1 : 64'(eps_reg);
        gabs  = (r.grad_sum < 0) ? 64'(-longint'(r.grad_sum)) : 64'(r.grad_sum);
        gsq   = (gabs * gabs) >> 16;
        ms_n  = (gam * 64'(msq_mirror[i]) + inv * gsq) >> 16;
        mgsum = longint'(gam) * longint'(mgrad_mirror[i]) + longint'(inv) * longint'(r.grad_sum);
        mg_n  = mgsum >>> 16;
        mgabs = (mg_n < 0) ? 64'(-mg_n) : 64'(mg_n);
        mgsq  = (mgabs * mgabs) >> 16;
        arg   = ((ms_n > mgsq) ? ms_n - mgsq : 64'd0) + (eps_v << 8);
        // floor square root, two bits a round
        x     = arg << 14;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x)
            bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= root + bit_v) begin
                x    = x - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
            bit_v = bit_v >> 2;
        end
        step = (64'(rate_reg) * gabs) / (2 * root);
        msq_mirror[i]   = ms_n[MS_W-1:0];
        mgrad_mirror[i] = int'(mg_n);
        w = longint'(weight_mirror[i]);
        if (r.grad_sum < 0)
            w = w + longint'(step);
        else
            w = w - longint'(step);
        if (w > 64'sd2147483647) begin
            w = 64'sd2147483647;
            o.saturated = 1'b1;
        end else if (w < -64'sd2147483648) begin
            w = -64'sd2147483648;
            o.saturated = 1'b1;
        end
        weight_mirror[i] = int'(w);
        o.new_weight     = w[31:0];
        return o;
    endfunction

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Driver: offer the next pending item, hold it until taken, idle at random or while paused
    always @(posedge clk)
    begin
        if (req_valid && req_ready) begin
            expected_weights.push_back(apply_request(req_data));
            items_in <= items_in + 1;
        end
        if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && !send_paused &&
                $urandom_range(99) >= send_idle_pct) begin
                req_valid <= 1'b1;
                req_data  <= pending_items[0];
                pending_items.delete(0);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go) begin
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare every result item with the oldest expectation
    always @(posedge clk)
    begin
        crmw_out_t exp_item;
        if (rsp_valid && rsp_ready) begin
            items_out <= items_out + 1;
            if (expected_weights.size() == 0) begin
                $error("unexpected result item, index %0d", rsp_data.out_index);
                err_cnt = err_cnt + 1;
            end else begin
                exp_item = expected_weights[0];
                expected_weights.delete(0);
                if (exp_item.saturated)
                    sat_seen <= sat_seen + 1;
                if (rsp_data.out_index !== exp_item.out_index) begin
                    $error("out_index: expected %0d, got %0d",
                           exp_item.out_index, rsp_data.out_index);
                    err_cnt = err_cnt + 1;
                end
                if (rsp_data.new_weight !== exp_item.new_weight) begin
                    $error("new_weight: expected %h, got %h",
                           exp_item.new_weight, rsp_data.new_weight);
                    err_cnt = err_cnt + 1;
                end
                if (rsp_data.saturated !== exp_item.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           exp_item.saturated, rsp_data.saturated);
                    err_cnt = err_cnt + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and phase control
    int loaded_list [$];
    bit is_loaded [NPARAM];

    // Write one register; valid stays up so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DECAY_GAMMA: gamma_reg = val[GAMMA_W-1:0];
            CFG_LEARN_RATE:  rate_reg  = val[RATE_W-1:0];
            default:         eps_reg   = val[RATE_W-1:0];
        endcase
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] lr,
                            input logic [CFG_DATA_W-1:0] e);
        write_reg(CFG_DECAY_GAMMA, g);
        write_reg(CFG_LEARN_RATE, lr);
        write_reg(CFG_EPSILON, e);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_load(input int idx, input logic [31:0] w);
        crmw_in_t it;
        it.req_type     = REQ_LOAD;
        it.param_index  = idx[IDX_W-1:0];
        it.weight_value = w;
        it.grad_sum     = $urandom;
        pending_items.push_back(it);
        if (!is_loaded[idx]) begin
            is_loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
        load_seen++;
    endtask

    task automatic push_update(input int idx, input logic [31:0] g);
        crmw_in_t it;
        it.req_type     = REQ_UPDATE;
        it.param_index  = idx[IDX_W-1:0];
        it.weight_value = $urandom;
        it.grad_sum     = g;
        pending_items.push_back(it);
    endtask

    // Wait until every item is sent and every result is back, then let the pipe settle
    task automatic drain();
        while (pending_items.size() > 0 || req_valid || expected_weights.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int k, idx, sel;
        logic [31:0] g;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 20 || loaded_list.size() == 0) begin
                push_load($urandom_range(NPARAM - 1), $urandom);
            end else begin
                // recent entries often, so the same-entry hold path gets exercised
                if ($urandom_range(99) < 30)
                    idx = loaded_list[loaded_list.size() - 1 -
                                      $urandom_range((loaded_list.size() < 4) ?
                                                     loaded_list.size() - 1 : 3)];
                else
                    idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
                sel = $urandom_range(99);
                if (sel < 40)
                    g = 32'($signed($urandom_range(131072)) - 65536);
                else if (sel < 80)
                    g = $urandom;
                else if (sel < 90)
                    g = '0;
                else
                    g = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
                push_update(idx, g);
            end
        end
    endtask

    initial
    begin
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of index and weight, both request kinds, zero gradient
        push_load(0, 32'h7FFF_FFFF);
        push_load(NPARAM - 1, 32'h8000_0000);
        push_load(341, 32'h0100_0000);
        push_load(682, 32'h0000_0000);
        push_update(0, 32'h0000_0000);
        push_update(NPARAM - 1, 32'h0000_0000);
        push_update(341, 32'h0000_1000);
        push_update(341, 32'hFFFF_F000);
        push_update(682, 32'h7FFF_FFFF);
        push_update(682, 32'h8000_0000);
        drain();

        // Large rate drives both ends into saturation; decay of one keeps averages fixed
        set_regs(31'd65536, 31'h7FFF_FFFF, 31'd1);
        push_update(0, 32'h8000_0000);
        push_update(NPARAM - 1, 32'h7FFF_FFFF);
        push_update(341, 32'h0000_0001);
        push_update(682, 32'hFFFF_FFFF);
        drain();

        // Decay above one and a zero epsilon, both clamped inside the core
        set_regs(31'h1_FFFF, 31'd16777, 31'd0);
        push_update(341, 32'h0123_4567);
        push_update(682, 32'hFEDC_BA98);
        push_update(0, 32'h0000_0000);
        drain();

        // Random phases: idling patterns, several register settings
        for (p = 0; p < 6; p++) begin
            case (p)
                0: set_regs(31'd58982, 31'd16777, 31'd17);
                1: set_regs(31'd0, 31'h0100_0000, 31'h7FFF_FFFF);
                2: set_regs(31'($urandom_range(65536)), 31'($urandom),
                            31'($urandom_range(1, 4096)));
                3: set_regs(31'd65535, 31'h7FFF_FFFF, 31'd1);
                4: set_regs(31'($urandom_range(131071)), 31'($urandom_range(1 << 20)),
                            31'($urandom));
                default: set_regs(31'd58982, 31'($urandom), 31'd0);
            endcase
            send_idle_pct <= (p < 2) ? 23 : (p < 4) ? 83 : 0;
            recv_idle_pct <= (p < 2) ? 83 : (p < 4) ? 23 : 0;
            random_phase(155);
            if (p == 4) begin
                // hold the output off while the sender keeps offering items
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            if (p == 2) begin
                // pause the sender until the pipe has emptied, then resume
                repeat (50) @(posedge clk);
                send_paused <= 1'b1;
                while (req_valid || expected_weights.size() > 0)
                    @(posedge clk);
                send_paused <= 1'b0;
            end
            drain();
        end

        if (expected_weights.size() > 0) begin
            $error("%0d result items never arrived", expected_weights.size());
            err_cnt = err_cnt + 1;
        end
        $display("Run covered %0d requests (%0d loads) and %0d results, %0d saturated,",
                 items_in, load_seen, items_out, sat_seen);
        $display("under nine register settings and three back-pressure patterns.");
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
